// ===== design/double_ended_queue_defines.svh =====
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define DEQ_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define DEQ_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/deq_pkg.sv =====
package deq_pkg;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_LIST_ALL   = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_POP_BACK   = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] element;
      logic [1:0]         status;
      logic               element_valid;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] status;
      logic       element_valid;
      logic       last_of_run;
   } meta_type;

endpackage

// ===== design/deq_chan_if.sv =====
interface deq_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit values in a single ring memory of CAPACITY entries,
// with a front index and a fill count. A push or pop is accepted and returns one status
// result; back to back pushes and pops sustain one per cycle while the result side keeps
// taking. A list command first enters the list state, then streams one element per cycle
// from front to back while the result side keeps taking, that pace set by the single read
// port of the ring memory; no new request is taken until the last element has been read
// out. No clearing pass runs after reset: only occupied entries are ever read.
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
   parameter int CAPACITY = 64
) (
   input logic         clock,
   input logic         reset,
   deq_chan_if.sink    req_chan,
   deq_chan_if.source  rsp_chan
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic signed [31:0] ring_mem [CAPACITY];
   logic signed [31:0] mem_q_ff;

   logic               state_ff, state_in;
   logic [IW-1:0]      front_ff, front_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      rd_addr_ff, rd_addr_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic               q_valid_ff, q_valid_in;
   deq_pkg::meta_type  q_meta_ff, q_meta_in;
   logic               rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type   rsp_data_ff;

   logic               advance;
   logic               q_free;
   logic               req_ready;
   logic               accept;
   logic               q_load;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic               rd_en;
   logic               full;
   logic               empty;
   logic [IW-1:0]      front_dec;
   logic [IW:0]        back_sum;
   logic [IW-1:0]      back_slot;

   function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
      logic [IW-1:0] r;
      if (s == IW'(CAPACITY - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

   assign advance   = !rsp_valid_ff || rsp_chan.ready;
   assign q_free    = !q_valid_ff || advance;
   assign req_ready = (state_ff == ST_IDLE) && q_free;
   assign accept    = req_chan.valid && req_ready;

   assign full      = (count_ff >= CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? IW'(CAPACITY - 1) : front_ff - 1'b1;
   assign back_sum  = {1'b0, front_ff} + (IW + 1)'(count_ff);
   assign back_slot = (back_sum >= (IW + 1)'(CAPACITY)) ?
                      IW'(back_sum - (IW + 1)'(CAPACITY)) : back_sum[IW-1:0];

   always_comb begin
      state_in   = state_ff;
      front_in   = front_ff;
      count_in   = count_ff;
      rd_addr_in = rd_addr_ff;
      rem_in     = rem_ff;
      wr_en      = 1'b0;
      wr_addr    = back_slot;
      rd_en      = 1'b0;
      q_load     = 1'b0;
      q_meta_in  = q_meta_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.data.cmd) inside
                  deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
                     q_load = 1'b1;
                     if (full) begin
                        q_meta_in = '{deq_pkg::STATUS_FULL, 1'b0, 1'b1};
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (req_chan.data.cmd == deq_pkg::CMD_PUSH_FRONT) begin
                           wr_addr  = front_dec;
                           front_in = front_dec;
                        end
                        q_meta_in = '{deq_pkg::STATUS_OK, 1'b0, 1'b1};
                     end
                  end
                  deq_pkg::CMD_LIST_ALL: begin
                     if (empty) begin
                        q_load    = 1'b1;
                        q_meta_in = '{deq_pkg::STATUS_EMPTY, 1'b0, 1'b1};
                     end else begin
                        state_in   = ST_LIST;
                        rd_addr_in = front_ff;
                        rem_in     = count_ff;
                     end
                  end
                  deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
                     q_load = 1'b1;
                     if (empty) begin
                        q_meta_in = '{deq_pkg::STATUS_EMPTY, 1'b0, 1'b1};
                     end else begin
                        count_in = count_ff - 1'b1;
                        if (req_chan.data.cmd == deq_pkg::CMD_POP_FRONT) begin
                           front_in = slot_inc(front_ff);
                        end
                        q_meta_in = '{deq_pkg::STATUS_OK, 1'b0, 1'b1};
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST: begin
            if (q_free) begin
               rd_en      = 1'b1;
               q_load     = 1'b1;
               q_meta_in  = '{deq_pkg::STATUS_OK, 1'b1, (rem_ff == CW'(1))};
               rd_addr_in = slot_inc(rd_addr_ff);
               rem_in     = rem_ff - 1'b1;
               if (rem_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (q_load) begin
         q_valid_in = 1'b1;
      end else if (advance) begin
         q_valid_in = 1'b0;
      end else begin
         q_valid_in = q_valid_ff;
      end
      rsp_valid_in = advance ? q_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= req_chan.data.item_value;
      end
      if (rd_en) begin
         mem_q_ff <= ring_mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         q_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         q_valid_ff   <= q_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      rem_ff     <= rem_in;
      if (q_load) begin
         q_meta_ff <= q_meta_in;
      end
      if (advance && q_valid_ff) begin
         rsp_data_ff.element       <= q_meta_ff.element_valid ? mem_q_ff : '0;
         rsp_data_ff.status        <= q_meta_ff.status;
         rsp_data_ff.element_valid <= q_meta_ff.element_valid;
         rsp_data_ff.last_of_run   <= q_meta_ff.last_of_run;
      end
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   `DEQ_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY),
      "fill count beyond capacity")
   `DEQ_ASSERT_IMPLIES(a_no_accept_in_list, clock, reset, state_ff == ST_LIST, !req_ready,
      "request accepted while listing")
   `DEQ_ASSERT_NEXT(a_push_counts, clock, reset,
      accept && !full && (req_chan.data.cmd == deq_pkg::CMD_PUSH_FRONT ||
      req_chan.data.cmd == deq_pkg::CMD_PUSH_BACK),
      count_ff == $past(count_ff) + 1'b1, "push did not advance fill count")

endmodule

// ===== bench/double_ended_queue_tb.sv =====
module double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;
   localparam int ITEMS = 250;
   localparam int TAIL_CYCLES = 16;

   typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_type;

   class deque_scoreboard #(int DEPTH = 64);
      logic signed [31:0]  ring [DEPTH];
      logic [5:0]          head;
      logic [6:0]          fill;
      deq_pkg::rsp_type    expected [$];
      int                  errors;
      int                  checked;
      int                  lists;
      int                  refused;
      int                  empties;

      function new();
         head = '0;
         fill = '0;
         errors = 0;
         checked = 0;
         lists = 0;
         refused = 0;
         empties = 0;
      endfunction

      function logic [5:0] slot(int i);
         return 6'(i % DEPTH);
      endfunction

      function int pending();
         return expected.size();
      endfunction

      task report(string msg);
         if (errors < 50) $display("ERROR: %s", msg);
         errors++;
      endtask

      function void note_request(deq_pkg::req_type r);
         deq_pkg::rsp_type e;
         int               i;
         e = '0;
         e.status = deq_pkg::STATUS_OK;
         e.last_of_run = 1'b1;
         case (r.cmd) inside
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
               if (fill >= DEPTH) begin
                  e.status = deq_pkg::STATUS_FULL;
                  refused++;
               end else begin
                  if (r.cmd == deq_pkg::CMD_PUSH_FRONT) begin
                     head = slot(head + DEPTH - 1);
                     ring[head] = r.item_value;
                  end else begin
                     ring[slot(head + fill)] = r.item_value;
                  end
                  fill++;
               end
               expected.push_back(e);
            end
            deq_pkg::CMD_LIST_ALL: begin
               lists++;
               if (fill == 0) begin
                  e.status = deq_pkg::STATUS_EMPTY;
                  empties++;
                  expected.push_back(e);
               end else begin
                  for (i = 0; i < fill; i++) begin
                     e.element = ring[slot(head + i)];
                     e.element_valid = 1'b1;
                     e.last_of_run = (i == fill - 1);
                     expected.push_back(e);
                  end
               end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
               if (fill == 0) begin
                  e.status = deq_pkg::STATUS_EMPTY;
                  empties++;
               end else begin
                  if (r.cmd == deq_pkg::CMD_POP_FRONT) head = slot(head + 1);
                  fill--;
               end
               expected.push_back(e);
            end
            default: ;
         endcase
      endfunction

      task check_result(deq_pkg::rsp_type got);
         deq_pkg::rsp_type want;
         if (expected.size() == 0) begin
            report($sformatf("result with nothing expected: %p", got));
            return;
         end
         want = expected.pop_front();
         if (got.element !== want.element)
            report($sformatf("result %0d element %0h, expected %0h",
                             checked, got.element, want.element));
         if (got.status !== want.status)
            report($sformatf("result %0d status %0d, expected %0d",
                             checked, got.status, want.status));
         if (got.element_valid !== want.element_valid)
            report($sformatf("result %0d element_valid %0b, expected %0b",
                             checked, got.element_valid, want.element_valid));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("result %0d last_of_run %0b, expected %0b",
                             checked, got.last_of_run, want.last_of_run));
         checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   logic calm;
   int   sent;

   deque_scoreboard #(DEPTH) sb;

   deq_chan_if #(.payload_type(deq_pkg::req_type)) req_chan ();
   deq_chan_if #(.payload_type(deq_pkg::rsp_type)) rsp_chan ();

   double_ended_queue #(.CAPACITY(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= calm || ($urandom_range(99) >= 16);
      end
   end

   // check results before noting requests of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) sb.check_result(rsp_chan.data);
         if (req_chan.valid && req_chan.ready) sb.note_request(req_chan.data);
      end
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task idle_gap();
      while (!calm && $urandom_range(99) < 16) begin
         req_chan.valid <= 1'b0;
         req_chan.data <= {3'($urandom), 32'($urandom)};
         @(posedge clock);
      end
   endtask

   task send_request(logic [2:0] cmd, logic signed [31:0] value);
      deq_pkg::req_type r;
      idle_gap();
      r.cmd = cmd;
      r.item_value = value;
      req_chan.valid <= 1'b1;
      req_chan.data <= r;
      do @(posedge clock); while (!req_chan.ready);
      if (cmd <= deq_pkg::CMD_POP_BACK) sent++;
   endtask

   // hold off until every expected result has arrived
   task settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task run_phase(phase_type kind, int len);
      int n;
      int r;
      int push_pct;
      int list_pct;
      int pop_pct;
      logic [2:0] cmd;
      case (kind)
         PHASE_FILL: begin
            push_pct = 88; list_pct = 2; pop_pct = 6;
         end
         PHASE_DRAIN: begin
            push_pct = 10; list_pct = 6; pop_pct = 80;
         end
         default: begin
            push_pct = 45; list_pct = 15; pop_pct = 35;
         end
      endcase
      for (n = 0; n < len && sent < ITEMS; n++) begin
         r = $urandom_range(99);
         if (r < push_pct)
            cmd = $urandom_range(1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
         else if (r < push_pct + list_pct)
            cmd = deq_pkg::CMD_LIST_ALL;
         else if (r < push_pct + list_pct + pop_pct)
            cmd = $urandom_range(1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
         else
            cmd = deq_pkg::CMD_POP_BACK + 3'($urandom_range(1, 3));
         send_request(cmd, pick_value());
      end
   endtask

   initial begin
      int        phase_no;
      phase_type kind;
      int        len;

      sb = new();
      sent = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(deq_pkg::CMD_POP_FRONT, 32'sh1234_5678);
      send_request(deq_pkg::CMD_POP_BACK, -32'sd1);
      send_request(deq_pkg::CMD_LIST_ALL, '0);
      send_request(deq_pkg::CMD_POP_BACK + 3'd1, 32'sh7fff_ffff);
      send_request(deq_pkg::CMD_POP_BACK + 3'd2, 32'sh8000_0000);
      send_request(deq_pkg::CMD_POP_BACK + 3'd3, -32'sd1);
      send_request(deq_pkg::CMD_PUSH_FRONT, 32'sh7fff_ffff);
      send_request(deq_pkg::CMD_PUSH_BACK, 32'sh8000_0000);
      send_request(deq_pkg::CMD_PUSH_FRONT, '0);
      send_request(deq_pkg::CMD_PUSH_BACK, -32'sd1);
      send_request(deq_pkg::CMD_LIST_ALL, 32'sh5555_5555);
      send_request(deq_pkg::CMD_POP_FRONT, '0);
      send_request(deq_pkg::CMD_LIST_ALL, '0);
      send_request(deq_pkg::CMD_POP_BACK, '0);
      send_request(deq_pkg::CMD_LIST_ALL, '0);
      send_request(deq_pkg::CMD_POP_FRONT, '0);
      send_request(deq_pkg::CMD_POP_BACK, '0);
      send_request(deq_pkg::CMD_POP_BACK, '0);
      send_request(deq_pkg::CMD_PUSH_BACK, 32'sh5555_5555);
      send_request(deq_pkg::CMD_PUSH_FRONT, 32'shaaaa_aaaa);
      send_request(deq_pkg::CMD_LIST_ALL, '0);
      send_request(deq_pkg::CMD_POP_FRONT, '0);
      send_request(deq_pkg::CMD_POP_FRONT, '0);
      send_request(deq_pkg::CMD_LIST_ALL, '0);
      settle();

      phase_no = 0;
      while (sent < ITEMS) begin
         if (phase_no == 0) begin
            kind = PHASE_FILL;
            len = 80;
         end else begin
            kind = phase_type'($urandom_range(2));
            len = $urandom_range(20, 70);
         end
         calm = (phase_no == 1);
         run_phase(kind, len);
         calm = 1'b0;
         if (phase_no == 0 || $urandom_range(2) == 0) settle();
         phase_no++;
      end

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests over %0d random phases: %0d lists, %0d refused pushes,",
               sent, phase_no, sb.lists, sb.refused);
      $display("%0d empty answers, %0d results checked, %0d mismatches.",
               sb.empties, sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
